// ----- hdl/fpsa_pkg.sv -----
package fpsa_pkg;

	localparam int MAX_PAGES   = 1024;
	localparam int PAGE_BYTES  = 4096;
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int ADDR_W      = 48;
	localparam int PN_W        = ADDR_W - PAGE_SHIFT;
	localparam int NPG_W       = PN_W + 1;
	localparam int CNT_W       = 11;
	localparam int IDX_W       = $clog2(MAX_PAGES);
	localparam int TYPE_W      = 16;
	localparam logic [TYPE_W-1:0] USABLE_TYPE = TYPE_W'(1);

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_ALLOC = 2'd2,
		OP_FREE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic count;
		logic push;
		logic resp;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic add_reject;
		logic alloc_empty;
		logic push_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hdl/fpsa_ctrl.sv -----
module fpsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fpsa_pkg::dp_stat_t  stat,
	output fpsa_pkg::ctrl_cmd_t cmd
);
	import fpsa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_COUNT  = 6'b000100,
		S_PUSH   = 6'b001000,
		S_READ   = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.op == OP_ADD && !stat.add_reject) begin
					state_d = S_COUNT;
				end else if (stat.op == OP_ALLOC && !stat.alloc_empty) begin
					state_d = S_READ;
				end else begin
					state_d = S_RESP;
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				state_d   = S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				if (stat.push_done) begin
					state_d = S_RESP;
				end
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.resp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/fpsa_dp.sv -----
module fpsa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpsa_pkg::ctrl_cmd_t           cmd,
	output fpsa_pkg::dp_stat_t            stat,
	input  logic [1:0]                    in_op,
	input  logic [fpsa_pkg::TYPE_W-1:0]   in_region_type,
	input  logic [fpsa_pkg::ADDR_W-1:0]   in_region_start,
	input  logic [fpsa_pkg::ADDR_W-1:0]   in_region_end,
	input  logic [fpsa_pkg::ADDR_W-1:0]   in_release_addr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fpsa_pkg::ADDR_W-1:0]   out_page_addr,
	output logic [1:0]                    out_status,
	output logic [fpsa_pkg::CNT_W-1:0]    out_free_count,
	output logic [fpsa_pkg::CNT_W-1:0]    out_total_count
);
	import fpsa_pkg::*;

	// request fields held for the whole transaction
	op_t               op_q;
	logic [TYPE_W-1:0] type_q;
	logic [NPG_W-1:0]  first_q;
	logic [PN_W-1:0]   end_q;
	logic [PN_W-1:0]   rel_q;
	logic              rel_zero_q;

	logic [NPG_W-1:0]  n_q;
	logic [PN_W-1:0]   cursor_q;
	logic              alloc_ok_q;
	status_t           status_q;

	logic [CNT_W-1:0]  top_q;
	logic [CNT_W-1:0]  total_q;
	logic              out_valid_q;

	logic [ADDR_W-1:0] page_out_q;
	status_t           status_out_q;
	logic [CNT_W-1:0]  free_out_q;
	logic [CNT_W-1:0]  total_out_q;

	logic [PN_W-1:0]   mem [MAX_PAGES];
	logic [PN_W-1:0]   rd_q;

	logic [ADDR_W:0]   start_rnd;
	logic              full;
	logic              empty;
	logic              rem_zero;
	logic              add_reject;
	logic              we;
	logic              re;
	logic [PN_W-1:0]   wdata;
	logic [CNT_W-1:0]  room;

	assign start_rnd  = {1'b0, in_region_start} + (ADDR_W+1)'(PAGE_BYTES - 1);
	assign full       = (top_q == CNT_W'(MAX_PAGES));
	assign empty      = (top_q == '0);
	assign rem_zero   = (n_q == '0);
	assign add_reject = (type_q != USABLE_TYPE) || (first_q >= {1'b0, end_q});
	assign room       = CNT_W'(MAX_PAGES) - total_q;

	assign we    = (cmd.decode && op_q == OP_FREE && !rel_zero_q && !full)
	             || (cmd.push && !rem_zero && !full);
	assign re    = cmd.decode && op_q == OP_ALLOC && !empty;
	assign wdata = (op_q == OP_FREE) ? rel_q : cursor_q;

	assign stat.op          = op_q;
	assign stat.add_reject  = add_reject;
	assign stat.alloc_empty = empty;
	assign stat.push_done   = rem_zero || full;
	assign stat.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[top_q[IDX_W-1:0]] <= wdata;
		end
		if (re) begin
			rd_q <= mem[top_q[IDX_W-1:0] - IDX_W'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op_t'(in_op);
			type_q     <= in_region_type;
			first_q    <= start_rnd[ADDR_W:PAGE_SHIFT];
			end_q      <= in_region_end[ADDR_W-1:PAGE_SHIFT];
			rel_q      <= in_release_addr[ADDR_W-1:PAGE_SHIFT];
			rel_zero_q <= (in_release_addr == '0);
			status_q   <= ST_OK;
			alloc_ok_q <= 1'b0;
		end
		if (cmd.decode) begin
			n_q      <= {1'b0, end_q} - first_q;
			cursor_q <= first_q[PN_W-1:0];
			case (op_q)
				OP_ADD: begin
					if (add_reject) begin
						status_q <= ST_IGNORED;
					end
				end
				OP_ALLOC: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						alloc_ok_q <= 1'b1;
					end
				end
				OP_FREE: begin
					if (rel_zero_q) begin
						status_q <= ST_IGNORED;
					end else if (full) begin
						status_q <= ST_FULL;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.push && !rem_zero) begin
			if (full) begin
				status_q <= ST_FULL;
			end else begin
				cursor_q <= cursor_q + PN_W'(1);
				n_q      <= n_q - NPG_W'(1);
			end
		end
		if (cmd.resp) begin
			page_out_q   <= alloc_ok_q ? {rd_q, {PAGE_SHIFT{1'b0}}} : '0;
			status_out_q <= status_q;
			free_out_q   <= top_q;
			total_out_q  <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decode && op_q == OP_CLEAR) begin
				top_q   <= '0;
				total_q <= '0;
			end else if (re) begin
				top_q <= top_q - CNT_W'(1);
			end else if (we) begin
				top_q <= top_q + CNT_W'(1);
			end
			// saturate the usable count at capacity
			if (cmd.count) begin
				if (n_q >= {{(NPG_W-CNT_W){1'b0}}, room}) begin
					total_q <= CNT_W'(MAX_PAGES);
				end else begin
					total_q <= total_q + n_q[CNT_W-1:0];
				end
			end
			if (cmd.resp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_page_addr   = page_out_q;
	assign out_status      = status_out_q;
	assign out_free_count  = free_out_q;
	assign out_total_count = total_out_q;

endmodule

// ----- hdl/free_page_stack_allocator_core.sv -----
// Flow: clear, free and rejected requests pass decode and then respond; allocate adds
// one registered stack read, and add region runs the count and push states before respond.
// Throughput: one transaction at a time; the next is taken once the FSM is back in
// idle, even while the previous result still waits in the output register.
// Region pushes run at one page per cycle through the single stack write port.
// Reset: arst_n clears stack pointer, usable count and output valid; stack RAM is not cleared.
module free_page_stack_allocator_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// region_type[15:0], region_start[63:16], region_end[111:64], release_addr[159:112]
	input  logic [159:0] s_axis_tdata,
	// op[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// page_addr[47:0], free_count[58:48], total_count[69:59], zero fill[71:70]
	output logic [71:0]  m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);
	import fpsa_pkg::*;

	ctrl_cmd_t         cmd;
	dp_stat_t          stat;
	logic [ADDR_W-1:0] page_addr;
	logic [CNT_W-1:0]  free_count;
	logic [CNT_W-1:0]  total_count;

	// Sequence each transaction: decode, optional count and push loop or stack read, then respond.
	fpsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stack RAM, pointer, counts and the result register that decouples the master side.
	fpsa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_op           (s_axis_tuser),
		.in_region_type  (s_axis_tdata[15:0]),
		.in_region_start (s_axis_tdata[63:16]),
		.in_region_end   (s_axis_tdata[111:64]),
		.in_release_addr (s_axis_tdata[159:112]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_page_addr   (page_addr),
		.out_status      (m_axis_tuser),
		.out_free_count  (free_count),
		.out_total_count (total_count)
	);

	// Pack the result fields from the lowest bit up and zero-fill to a whole byte.
	assign m_axis_tdata = {2'b00, total_count, free_count, page_addr};

endmodule

// ----- bench/free_page_stack_allocator_core_tb.sv -----
module free_page_stack_allocator_core_tb;
	import fpsa_pkg::*;

	typedef struct {
		op_t               op;
		logic [TYPE_W-1:0] rtype;
		logic [ADDR_W-1:0] rstart;
		logic [ADDR_W-1:0] rend;
		logic [ADDR_W-1:0] raddr;
	} page_req_t;

	typedef struct {
		logic [ADDR_W-1:0] page_addr;
		status_t           status;
		logic [CNT_W-1:0]  free_cnt;
		logic [CNT_W-1:0]  total_cnt;
	} page_resp_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	free_page_stack_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	page_req_t  request_queue[$];
	page_resp_t pending_responses[$];

	// shadow copy of the page stack and its counters
	logic [PN_W-1:0] shadow_stack [MAX_PAGES];
	int unsigned     shadow_top;
	int unsigned     shadow_total;

	int   requests_taken;
	int   mismatch_count;
	int   op_seen [4];
	int   status_seen [4];
	logic in_fire;
	logic steady;

	// no idling on either side through this stretch of requests
	assign steady = (requests_taken >= 450) && (requests_taken < 750);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rand48();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	// compute the response to one request and advance the shadow stack
	function automatic page_resp_t predict_response(page_req_t req);
		page_resp_t  rsp;
		logic [63:0] lo_page;
		logic [63:0] hi_page;
		logic [63:0] npages;
		logic [63:0] room;
		logic [63:0] take;
		rsp.page_addr = '0;
		rsp.status    = ST_OK;
		case (req.op)
			OP_CLEAR: begin
				shadow_top   = 0;
				shadow_total = 0;
			end
			OP_ADD: begin
				// round start up and end down to whole pages
				lo_page = (64'(req.rstart) + PAGE_BYTES - 1) >> PAGE_SHIFT;
				hi_page = 64'(req.rend) >> PAGE_SHIFT;
				if (req.rtype != USABLE_TYPE || lo_page >= hi_page) begin
					rsp.status = ST_IGNORED;
				end else begin
					npages = hi_page - lo_page;
					room   = MAX_PAGES - shadow_top;
					take   = (npages < room) ? npages : room;
					// push lowest page first, drop whatever does not fit
					for (int unsigned j = 0; j < take; j++) begin
						shadow_stack[shadow_top] = PN_W'(lo_page + j);
						shadow_top++;
					end
					if (take < npages)
						rsp.status = ST_FULL;
					if (npages >= 64'(MAX_PAGES - shadow_total))
						shadow_total = MAX_PAGES;
					else
						shadow_total += int'(npages);
				end
			end
			OP_ALLOC: begin
				if (shadow_top == 0) begin
					rsp.status = ST_EMPTY;
				end else begin
					shadow_top--;
					rsp.page_addr = ADDR_W'(64'(shadow_stack[shadow_top]) << PAGE_SHIFT);
				end
			end
			default: begin
				if (req.raddr == '0) begin
					rsp.status = ST_IGNORED;
				end else if (shadow_top >= MAX_PAGES) begin
					rsp.status = ST_FULL;
				end else begin
					shadow_stack[shadow_top] = PN_W'(req.raddr >> PAGE_SHIFT);
					shadow_top++;
				end
			end
		endcase
		rsp.free_cnt  = CNT_W'(shadow_top);
		rsp.total_cnt = CNT_W'(shadow_total);
		return rsp;
	endfunction

	task automatic post(op_t op, logic [TYPE_W-1:0] rtype, logic [ADDR_W-1:0] rstart,
			logic [ADDR_W-1:0] rend, logic [ADDR_W-1:0] raddr);
		page_req_t req;
		req.op     = op;
		req.rtype  = rtype;
		req.rstart = rstart;
		req.rend   = rend;
		req.raddr  = raddr;
		request_queue.push_back(req);
	endtask

	// page-aligned base: half the time near the bottom of memory, otherwise anywhere
	function automatic logic [ADDR_W-1:0] page_base();
		logic [63:0] pn;
		if ($urandom_range(0, 1) == 0)
			pn = 64'($urandom_range(0, 4096));
		else
			pn = 64'(rand48()) >> PAGE_SHIFT;
		return ADDR_W'(pn << PAGE_SHIFT);
	endfunction

	// driver: present the next request at the falling edge, hold it until taken
	always @(negedge clk) begin : drive_requests
		page_req_t req;
		if (arst_n) begin
			if (!s_axis_tvalid || in_fire) begin
				if (request_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 18)) begin
					req = request_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {req.raddr, req.rend, req.rstart, req.rtype};
					s_axis_tuser  <= req.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
		end
	end

	// monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin : watch_ports
		page_req_t  req;
		page_resp_t want;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			req.op     = op_t'(s_axis_tuser);
			req.rtype  = s_axis_tdata[15:0];
			req.rstart = s_axis_tdata[63:16];
			req.rend   = s_axis_tdata[111:64];
			req.raddr  = s_axis_tdata[159:112];
			pending_responses.push_back(predict_response(req));
			op_seen[req.op]++;
			requests_taken++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_responses.size() == 0) begin
				$error("response with none outstanding: tdata %h tuser %h",
					m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				want = pending_responses.pop_front();
				status_seen[m_axis_tuser]++;
				if (m_axis_tdata[47:0] !== want.page_addr) begin
					$error("page_addr: expected %h, got %h", want.page_addr, m_axis_tdata[47:0]);
					mismatch_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					mismatch_count++;
				end
				if (m_axis_tdata[58:48] !== want.free_cnt) begin
					$error("free_count: expected %0d, got %0d", want.free_cnt,
						m_axis_tdata[58:48]);
					mismatch_count++;
				end
				if (m_axis_tdata[69:59] !== want.total_cnt) begin
					$error("total_count: expected %0d, got %0d", want.total_cnt,
						m_axis_tdata[69:59]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int          total_posted;
		int          pick;
		int          variant;
		bit          draining;
		logic [ADDR_W-1:0] base;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = OP_CLEAR;
		m_axis_tready  = 1'b0;
		in_fire        = 1'b0;
		arst_n         = 1'b0;
		shadow_top     = 0;
		shadow_total   = 0;
		requests_taken = 0;
		mismatch_count = 0;

		// directed corner cases
		post(OP_ALLOC, '0, '0, '0, '0);                          // allocate from empty store
		post(OP_FREE, 16'hFFFF, '1, '1, '0);                     // free of zero is ignored
		post(OP_FREE, '0, '0, '0, 48'h1);                        // address inside page zero
		post(OP_ALLOC, '0, '0, '0, '0);                          // page zero comes back as 0, ok
		post(OP_ADD, 16'h0000, 48'h1000, 48'h9000, '0);          // unusable type
		post(OP_ADD, 16'hFFFF, 48'h1000, 48'h9000, '0);          // unusable type
		post(OP_ADD, USABLE_TYPE, 48'h3000, 48'h3000, '0);       // empty region
		post(OP_ADD, USABLE_TYPE, 48'h1001, 48'h1FFF, '0);       // empty after rounding
		post(OP_ADD, USABLE_TYPE, 48'h8000, 48'h2000, '0);       // inverted region
		post(OP_ADD, USABLE_TYPE, 48'h1001, 48'h5000, '0);       // pages 2, 3, 4
		post(OP_ALLOC, '0, '0, '0, '0);
		post(OP_ALLOC, '0, '0, '0, '0);
		post(OP_FREE, '0, '0, '0, 48'hFFFF_FFFF_FFFF);           // top page, low bits dropped
		post(OP_FREE, '0, '0, '0, 48'h7ABC);                     // double free
		post(OP_FREE, '0, '0, '0, 48'h7ABC);
		post(OP_ALLOC, '0, '0, '0, '0);
		post(OP_ALLOC, '0, '0, '0, '0);
		post(OP_ALLOC, '0, '0, '0, '0);
		post(OP_ADD, USABLE_TYPE, 48'h0, 48'h50_0000, '0);       // overflows the store
		post(OP_FREE, '0, '0, '0, 48'h1234_5000);                // free when full
		post(OP_ADD, USABLE_TYPE, 48'h2000, 48'h3000, '0);       // add when full
		post(OP_CLEAR, '1, '1, '1, '1);
		post(OP_ADD, USABLE_TYPE, 48'hFFFF_FFFF_F001, '1, '0);   // start rounds past the top
		post(OP_ADD, USABLE_TYPE, 48'hFFFF_FFFF_E000, '1, '0);   // page just below the top page of memory
		post(OP_ALLOC, '0, '0, '0, '0);
		post(OP_ADD, USABLE_TYPE, '0, '1, '0);                   // huge region, count saturates
		post(OP_CLEAR, '0, '0, '0, '0);

		// random part: alternate filling and draining phases
		for (int i = 0; i < 1100; i++) begin
			draining = ((i / 150) % 2) == 1;
			pick     = $urandom_range(0, 99);
			if (pick < 2) begin
				post(OP_CLEAR, 16'($urandom), rand48(), rand48(), rand48());
			end else if (draining ? (pick < 82) : (pick < 24)) begin
				post(OP_ALLOC, 16'($urandom), rand48(), rand48(), rand48());
			end else if (draining ? (pick < 87) : (pick < 57)) begin
				variant = $urandom_range(0, 99);
				base    = page_base() | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
				if (variant < 3) begin
					// large region, up to beyond capacity
					post(OP_ADD, USABLE_TYPE, base,
						base + ADDR_W'(64'($urandom_range(100, 1300)) << PAGE_SHIFT),
						rand48());
				end else if (variant < 10) begin
					// noise: random type and random bounds
					post(OP_ADD, 16'($urandom), rand48(), rand48(), rand48());
				end else if (variant < 16) begin
					// usable type but nothing whole inside
					post(OP_ADD, USABLE_TYPE, base,
						base - ADDR_W'($urandom_range(0, 3 * PAGE_BYTES)), rand48());
				end else begin
					post(OP_ADD, USABLE_TYPE, base,
						base + ADDR_W'(64'($urandom_range(0, draining ? 4 : 24)) << PAGE_SHIFT)
						+ ADDR_W'($urandom_range(0, PAGE_BYTES - 1)),
						rand48());
				end
			end else begin
				variant = $urandom_range(0, 99);
				if (variant < 5)
					base = '0;
				else if (variant < 12)
					base = rand48();
				else if (variant < 20)
					base = ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
				else
					base = page_base() | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
				post(OP_FREE, 16'($urandom), rand48(), rand48(), base);
			end
		end
		total_posted = request_queue.size();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// wait for every request to be taken and answered, then watch for strays
		while (requests_taken < total_posted || pending_responses.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("requests: %0d clear, %0d add, %0d allocate, %0d free",
			op_seen[OP_CLEAR], op_seen[OP_ADD], op_seen[OP_ALLOC], op_seen[OP_FREE]);
		$display("responses: %0d ok, %0d empty, %0d full, %0d ignored",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
			status_seen[ST_IGNORED]);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(400000 * 12);
		$display("timeout waiting for responses");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
